[src/rlls_pkg.sv]
// Package for the run-length level statistics unit.
// Holds the counter widths, the window snapshot types and the saturating increment.
// No dependencies.
package rlls_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int OUT_W       = 16;
  localparam int WIN_W       = 16;
  localparam int MIN_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DIV_CNT_W   = $clog2(COUNT_WIDTH);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [MIN_W-1:0]       min_t;
  typedef logic [WIN_W-1:0]       win_t;
  typedef logic [OUT_W-1:0]       out_t;

  localparam count_t COUNT_MAX    = '1;
  localparam min_t   MIN_NONE     = MIN_W'(16'hffff);
  localparam win_t   WINDOW_RESET = WIN_W'(10000);

  typedef struct packed {
    min_t   min_run;
    count_t max_run;
    count_t samples;
    count_t runs;
  } level_stats_t;

  typedef struct packed {
    level_stats_t high;
    level_stats_t low;
  } snapshot_t;

  function automatic count_t sat_inc(count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

endpackage

[src/rlls_in_if.sv]
// Sample channel of the run-length level statistics unit.
// Depends on nothing.
interface rlls_in_if;
  logic valid;
  logic ready;
  logic sample_bit;

  modport source (output valid, output sample_bit, input ready);
  modport sink   (input valid, input sample_bit, output ready);
endinterface

[src/rlls_out_if.sv]
// Report channel of the run-length level statistics unit.
// Depends on nothing.
interface rlls_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] low_min_run;
  logic [15:0] low_max_run;
  logic [15:0] low_avg_run;
  logic [15:0] low_run_count;
  logic [15:0] high_min_run;
  logic [15:0] high_max_run;
  logic [15:0] high_avg_run;
  logic [15:0] high_run_count;

  modport source (output valid, output low_min_run, output low_max_run, output low_avg_run,
                  output low_run_count, output high_min_run, output high_max_run,
                  output high_avg_run, output high_run_count, input ready);
  modport sink   (input valid, input low_min_run, input low_max_run, input low_avg_run,
                  input low_run_count, input high_min_run, input high_max_run,
                  input high_avg_run, input high_run_count, output ready);
endinterface

[src/run_length_level_statistics_unit.sv]
// Run-length level statistics unit: top level joining front end, snapshot queue and back end.
// Depends on rlls_pkg, rlls_in_if, rlls_out_if, rlls_front, rlls_queue and rlls_back.
//
// The unit takes one sampled line level per transfer on in_ch and accepts a sample every
// cycle while the queue has room; statistics are updated in the same cycle the sample is
// taken. After window_length samples (cfg_wdata written with cfg_we, reset 10000, zero
// meaning 65536) the front end pushes a snapshot of the window into a two-entry queue and
// restarts from a low level with no run. The back end pops a snapshot, forms both averages
// with one restoring divider step per level per cycle, then presents the report on out_ch
// until it is taken. The back end takes a new window only after the report of the last one
// has been taken, and in_ch drops ready only while the queue holds two unserved windows.
module run_length_level_statistics_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  rlls_in_if.sink     in_ch,
  rlls_out_if.source  out_ch
);
  import rlls_pkg::*;

  // front end to queue
  logic      push_valid;
  logic      push_ready;
  snapshot_t push_data;
  // queue to back end
  logic      pop_valid;
  logic      pop_ready;
  snapshot_t pop_data;

  // classify samples and hold the running window
  rlls_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // decouple the sample rate from the divider
  rlls_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // divide and hold the report for transfer
  rlls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

[src/rlls_front.sv]
// Front end: takes samples, tracks runs and per-level statistics, emits a window snapshot.
// Depends on rlls_pkg and rlls_in_if.
module rlls_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  rlls_in_if.sink            in_ch,
  output logic               push_valid,
  output rlls_pkg::snapshot_t push_data,
  input  logic               push_ready
);
  import rlls_pkg::*;

  win_t   window_length_r;
  win_t   pos_r;
  logic   prev_r;
  count_t run_r;
  min_t   min_r     [2];
  count_t max_r     [2];
  count_t samples_r [2];
  count_t runs_r    [2];

  min_t   min_nxt     [2];
  count_t max_nxt     [2];
  count_t samples_nxt [2];
  count_t runs_nxt    [2];
  count_t run_nxt;
  logic   cur;
  logic   change;
  logic   accept;
  logic   report;
  logic [WIN_W:0] seen;
  logic [WIN_W:0] limit;

  // a report needs queue space, so stall whenever the queue is full
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cur         = in_ch.sample_bit;
  assign change      = (cur != prev_r);

  always_comb begin
    run_nxt = change ? count_t'(1) : sat_inc(run_r);
    for (int k = 0; k < 2; k++) begin
      min_nxt[k]     = min_r[k];
      max_nxt[k]     = max_r[k];
      samples_nxt[k] = samples_r[k];
      runs_nxt[k]    = runs_r[k];
      if (change && (prev_r == 1'(k))) begin
        if ((run_r != '0) && (MIN_W'(run_r) < min_r[k])) begin
          min_nxt[k] = MIN_W'(run_r);
        end
        if (run_r > max_r[k]) begin
          max_nxt[k] = run_r;
        end
        runs_nxt[k] = sat_inc(runs_r[k]);
      end
      if (cur == 1'(k)) begin
        samples_nxt[k] = sat_inc(samples_r[k]);
      end
    end
    seen   = {1'b0, pos_r} + (WIN_W+1)'(1);
    limit  = (window_length_r == '0) ? {1'b1, {WIN_W{1'b0}}} : {1'b0, window_length_r};
    report = (seen >= limit);
  end

  assign push_valid = accept && report;
  assign push_data.low  = '{min_run: min_nxt[0], max_run: max_nxt[0],
                            samples: samples_nxt[0], runs: runs_nxt[0]};
  assign push_data.high = '{min_run: min_nxt[1], max_run: max_nxt[1],
                            samples: samples_nxt[1], runs: runs_nxt[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_length_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && report)) begin
      pos_r  <= '0;
      prev_r <= 1'b0;
      run_r  <= '0;
      for (int k = 0; k < 2; k++) begin
        min_r[k]     <= MIN_NONE;
        max_r[k]     <= '0;
        samples_r[k] <= '0;
        runs_r[k]    <= '0;
      end
    end else if (accept) begin
      pos_r  <= seen[WIN_W-1:0];
      prev_r <= cur;
      run_r  <= run_nxt;
      for (int k = 0; k < 2; k++) begin
        min_r[k]     <= min_nxt[k];
        max_r[k]     <= max_nxt[k];
        samples_r[k] <= samples_nxt[k];
        runs_r[k]    <= runs_nxt[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_window_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && report) |=> (pos_r == '0 && prev_r == 1'b0 && run_r == '0))
    else $error("statistics not cleared after a report");
`endif

endmodule

[src/rlls_queue.sv]
// Short snapshot queue between the front end and the divider back end.
// Depends on rlls_pkg.
module rlls_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  rlls_pkg::snapshot_t push_data,
  output logic                push_ready,
  output logic                pop_valid,
  output rlls_pkg::snapshot_t pop_data,
  input  logic                pop_ready
);
  import rlls_pkg::*;

  snapshot_t           q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("snapshot queue overfilled");
  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + (QPTR_W+1)'(1)))
    else $error("queue fill level lost a snapshot");
`endif

endmodule

[src/rlls_back.sv]
// Back end: divides samples by runs for both levels, one quotient bit a cycle, and holds the report.
// Depends on rlls_pkg and rlls_out_if.
module rlls_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  input  rlls_pkg::snapshot_t pop_data,
  output logic                pop_ready,
  rlls_out_if.source          out_ch
);
  import rlls_pkg::*;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_DIV  = 2'd1;
  localparam logic [1:0] BK_OUT  = 2'd2;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(COUNT_WIDTH - 1);

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  snapshot_t            snap_r;
  count_t               quo_r [2];
  count_t               rem_r [2];
  count_t               quo_nxt [2];
  count_t               rem_nxt [2];
  count_t               divisor [2];
  logic [COUNT_WIDTH:0] trial [2];
  logic                 do_pop;

  assign pop_ready  = (state_r == BK_IDLE);
  assign do_pop     = pop_valid && pop_ready;
  assign divisor[0] = snap_r.low.runs;
  assign divisor[1] = snap_r.high.runs;

  // one restoring step per lane
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      trial[k] = {rem_r[k], quo_r[k][COUNT_WIDTH-1]};
      if (trial[k] >= {1'b0, divisor[k]}) begin
        rem_nxt[k] = COUNT_WIDTH'(trial[k] - {1'b0, divisor[k]});
        quo_nxt[k] = {quo_r[k][COUNT_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][COUNT_WIDTH-1:0];
        quo_nxt[k] = {quo_r[k][COUNT_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (pop_valid) state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == LAST_STEP) state_nxt = BK_OUT;
      BK_OUT:  if (out_ch.ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (do_pop) begin
        cnt_r <= '0;
      end else if (state_r == BK_DIV) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      snap_r   <= pop_data;
      quo_r[0] <= pop_data.low.samples;
      quo_r[1] <= pop_data.high.samples;
      rem_r[0] <= '0;
      rem_r[1] <= '0;
    end else if (state_r == BK_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign out_ch.valid          = (state_r == BK_OUT);
  assign out_ch.low_min_run    = OUT_W'(snap_r.low.min_run);
  assign out_ch.low_max_run    = OUT_W'(snap_r.low.max_run);
  assign out_ch.low_avg_run    = (divisor[0] == '0) ? '0 : OUT_W'(quo_r[0]);
  assign out_ch.low_run_count  = OUT_W'(snap_r.low.runs);
  assign out_ch.high_min_run   = OUT_W'(snap_r.high.min_run);
  assign out_ch.high_max_run   = OUT_W'(snap_r.high.max_run);
  assign out_ch.high_avg_run   = (divisor[1] == '0) ? '0 : OUT_W'(quo_r[1]);
  assign out_ch.high_run_count = OUT_W'(snap_r.high.runs);

`ifndef SYNTHESIS
  a_pop_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (state_r == BK_DIV && cnt_r == '0))
    else $error("snapshot taken without starting the division");
  a_report_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> ($past(state_r) == BK_DIV && $past(cnt_r) == LAST_STEP))
    else $error("report shown before the division finished");
`endif

endmodule
